// ----- hdl/lru_handle_cache_defines.svh -----
// Assertion macros shared by the handle cache RTL.
`ifndef LRU_HANDLE_CACHE_DEFINES_SVH
`define LRU_HANDLE_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LRUC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lruc assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LRUC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lruc assertion failed");

`endif

// ----- hdl/lruc_pkg.sv -----
// Package with the shared constants and types of the handle cache.
package lruc_pkg;

  localparam int KEY_W        = 64;
  localparam int SLOT_W       = 4;
  localparam int CNT_W        = 32;
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 64;

  typedef struct packed {
    logic match;
    logic chain;
  } lruc_stat_t;

endpackage

// ----- hdl/lruc_cell.sv -----
// One recency position of the cache: a slot index, its key and its valid bit.
module lruc_cell #(
  parameter int IDX_W    = 4,
  parameter int KEY_BITS = 64,
  parameter int RST_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_BITS-1:0]  key_i,
  input  logic                 shift_i,
  input  logic                 chain_i,
  input  logic [IDX_W-1:0]     nxt_idx_i,
  input  logic [KEY_BITS-1:0]  nxt_key_i,
  input  logic                 nxt_vld_i,
  output logic [IDX_W-1:0]     idx_o,
  output logic [KEY_BITS-1:0]  key_o,
  output logic                 vld_o,
  output lruc_pkg::lruc_stat_t stat_o
);
  import lruc_pkg::*;

  logic [IDX_W-1:0]    idx_q;
  logic [KEY_BITS-1:0] key_q;
  logic                vld_q;
  logic                match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IDX_W'(RST_IDX);
      vld_q <= 1'b0;
    end else if (shift_i) begin
      idx_q <= nxt_idx_i;
      vld_q <= nxt_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= nxt_key_i;
    end
  end

  assign match        = vld_q && (key_q == key_i);
  assign stat_o.match = match;
  assign stat_o.chain = chain_i | match;
  assign idx_o        = idx_q;
  assign key_o        = key_q;
  assign vld_o        = vld_q;

endmodule

// ----- hdl/lru_handle_cache.sv -----
// Top level of the fully associative handle cache with LRU replacement.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      key_i, open_ok_i
//   out      output     out_valid_o / out_stall_i    hit_o, open_failed_o, slot_o, evict_o,
//                                                    evicted_key_o, hit_total_o, miss_total_o
//
// A word is taken every cycle while in_stall_o is low; its result is in the output register in the cycle after.
// The cells form a chain ordered by recency, least recent at position 0, and the hit
// search ripples through that chain once per word.
// Reset empties all slots and sets slot i at recency position i; no clearing pass follows.
// While the output register holds an untaken word and out_stall_i is high, in_stall_o is high.
`include "lru_handle_cache_defines.svh"

module lru_handle_cache #(
  parameter int ENTRIES  = lruc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lruc_pkg::KEY_W-1:0] key_i,
  input  logic                       open_ok_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic                       open_failed_o,
  output logic [lruc_pkg::SLOT_W-1:0] slot_o,
  output logic                       evict_o,
  output logic [lruc_pkg::KEY_W-1:0] evicted_key_o,
  output logic [lruc_pkg::CNT_W-1:0] hit_total_o,
  output logic [lruc_pkg::CNT_W-1:0] miss_total_o
);
  import lruc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  logic [KEY_BITS-1:0] lookup_key;
  logic                in_acc;

  logic [IDX_W-1:0]    cell_idx [ENTRIES];
  logic [KEY_BITS-1:0] cell_key [ENTRIES];
  logic                cell_vld [ENTRIES];
  logic [IDX_W-1:0]    nxt_idx  [ENTRIES];
  logic [KEY_BITS-1:0] nxt_key  [ENTRIES];
  logic                nxt_vld  [ENTRIES];
  logic                chain_in [ENTRIES];
  logic                shift    [ENTRIES];
  lruc_stat_t          stat     [ENTRIES];
  logic [ENTRIES-1:0]  match_vec;

  logic                any_hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    slot_idx;
  logic                evict;
  logic [IDX_W-1:0]    top_idx;
  logic                top_vld;
  logic [SLOT_W+IDX_W-1:0]  slot_wide;
  logic [KEY_W+KEY_BITS-1:0] ekey_wide;

  logic [CNT_W-1:0]    hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]    miss_cnt_q, miss_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                hit_q, failed_q, evict_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [KEY_W-1:0]    ekey_q;

  assign lookup_key = key_i[KEY_BITS-1:0];
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign chain_in[gi] = 1'b0;
    end else begin : g_rest
      assign chain_in[gi] = stat[gi-1].chain;
    end

    if (gi == ENTRIES - 1) begin : g_top
      assign nxt_idx[gi] = top_idx;
      assign nxt_key[gi] = lookup_key;
      assign nxt_vld[gi] = top_vld;
    end else begin : g_mid
      assign nxt_idx[gi] = cell_idx[gi+1];
      assign nxt_key[gi] = cell_key[gi+1];
      assign nxt_vld[gi] = cell_vld[gi+1];
    end

    assign shift[gi]     = in_acc & (~any_hit | stat[gi].chain);
    assign match_vec[gi] = stat[gi].match;

    lruc_cell #(
      .IDX_W    (IDX_W),
      .KEY_BITS (KEY_BITS),
      .RST_IDX  (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (lookup_key),
      .shift_i   (shift[gi]),
      .chain_i   (chain_in[gi]),
      .nxt_idx_i (nxt_idx[gi]),
      .nxt_key_i (nxt_key[gi]),
      .nxt_vld_i (nxt_vld[gi]),
      .idx_o     (cell_idx[gi]),
      .key_o     (cell_key[gi]),
      .vld_o     (cell_vld[gi]),
      .stat_o    (stat[gi])
    );
  end

  assign any_hit = stat[ENTRIES-1].chain;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (stat[i].match) begin
        hit_idx = hit_idx | cell_idx[i];
      end
    end
  end

  assign slot_idx  = any_hit ? hit_idx : cell_idx[0];
  assign evict     = ~any_hit & cell_vld[0];
  assign top_idx   = slot_idx;
  assign top_vld   = any_hit | open_ok_i;
  assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};
  assign ekey_wide = {{KEY_W{1'b0}}, (evict ? cell_key[0] : {KEY_BITS{1'b0}})};

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (in_acc) begin
      if (any_hit) begin
        if (hit_cnt_q != {CNT_W{1'b1}}) begin
          hit_cnt_d = hit_cnt_q + CNT_W'(1);
        end
      end else if (open_ok_i) begin
        if (miss_cnt_q != {CNT_W{1'b1}}) begin
          miss_cnt_d = miss_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hit_q    <= any_hit;
      failed_q <= ~any_hit & ~open_ok_i;
      slot_q   <= slot_wide[SLOT_W-1:0];
      evict_q  <= evict;
      ekey_q   <= ekey_wide[KEY_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign open_failed_o = failed_q;
  assign slot_o        = slot_q;
  assign evict_o       = evict_q;
  assign evicted_key_o = ekey_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;

  `LRUC_ASSERT_NOW(a_single_match, 1'b1, $onehot0(match_vec))
  `LRUC_ASSERT_NOW(a_evict_on_miss, out_valid_o && (evict_o || open_failed_o), !hit_o)
  `LRUC_ASSERT_NEXT(a_hit_counted, in_acc && any_hit, out_valid_q && hit_q && (hit_cnt_q != '0))

endmodule
